// ===== src/qrpb_pkg.sv =====
// Package for the quadrilateral region point binner.
// Holds opcodes, controller state codes and the command and status words
// shared by the controller and the datapath. Depends on nothing.
package qrpb_pkg;

    // Widths fixed by the port definition.
    localparam int PORT_COORD_BITS = 16;
    localparam int BIN_BITS        = 4;
    localparam int COUNT_BITS      = 5;

    // Four corners to a region; the walk over one region reads corner 0 again
    // at its end so that the closing edge looks like every other edge.
    localparam int         CORNERS      = 4;
    localparam logic [2:0] FIRST_CORNER = 3'd0;
    localparam logic [2:0] CLOSE_CORNER = 3'd4;

    localparam logic OP_LOAD     = 1'b0;
    localparam logic OP_CLASSIFY = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_RUN   = 3'b010,
        S_DRAIN = 3'b100
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic write;       // store one vertex from the input ports
        logic load_point;  // capture the query point
        logic issue;       // read one corner into the edge pipeline
        logic flush;       // drop everything in flight
    } t_dp_cmd;

    // Status from the datapath: a region has been fully tested.
    typedef struct packed {
        logic region_done;
        logic hit;
    } t_dp_status;

endpackage

// ===== src/qrpb_ctrl.sv =====
// Controller of the quadrilateral region point binner.
// Holds the region count register, walks regions and corners, and owns the
// result strobe and payload registers. Uses qrpb_pkg.
module qrpb_ctrl
    import qrpb_pkg::*;
#(
    parameter int REGIONS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_opcode,
    input  logic [3:0]                    i_region_index,
    input  logic                          i_cfg_we,
    input  logic [COUNT_BITS-1:0]         i_cfg_wdata,
    output t_dp_cmd                       o_cmd,
    output logic [((REGIONS > 1) ? $clog2(REGIONS) : 1)-1:0] o_rd_region,
    output logic [2:0]                    o_rd_corner,
    input  t_dp_status                    i_status,
    input  logic [((REGIONS > 1) ? $clog2(REGIONS) : 1)-1:0] i_status_region,
    output logic                          o_done,
    output logic                          o_found,
    output logic [BIN_BITS-1:0]           o_bin_index
);

    localparam int RW = (REGIONS > 1) ? $clog2(REGIONS) : 1;
    localparam int AW = RW + 1;

    t_state                r_state, n_state;
    logic [COUNT_BITS-1:0] r_region_count;
    logic [AW-1:0]         r_active, n_active;
    logic [RW-1:0]         r_region, n_region;
    logic [2:0]            r_corner, n_corner;
    logic                  r_done, n_done;
    logic                  r_found, n_found;
    logic [BIN_BITS-1:0]   r_bin, n_bin;

    logic          accept, load_ok, classify;
    logic          working, last_region, last_status;
    logic          finish_hit, finish_miss, finish;
    logic [AW-1:0] active_cap;

    assign busy     = (r_state != S_IDLE);
    assign accept   = start & ~busy;
    assign classify = accept & (i_opcode == OP_CLASSIFY);
    assign load_ok  = accept & (i_opcode == OP_LOAD) & (int'(i_region_index) < REGIONS);

    // A count above the table size means the whole table.
    assign active_cap = (int'(r_region_count) > REGIONS) ? AW'(REGIONS)
                                                        : AW'(r_region_count);

    assign working     = (r_state == S_RUN) || (r_state == S_DRAIN);
    assign last_region = (AW'(r_region) == r_active - AW'(1));
    assign last_status = (AW'(i_status_region) == r_active - AW'(1));
    assign finish_hit  = working & i_status.region_done & i_status.hit;
    assign finish_miss = working & i_status.region_done & ~i_status.hit & last_status;
    assign finish      = finish_hit | finish_miss;

    assign o_cmd.write      = load_ok;
    assign o_cmd.load_point = classify;
    assign o_cmd.issue      = (r_state == S_RUN) & ~finish;
    assign o_cmd.flush      = finish;
    assign o_rd_region      = r_region;
    assign o_rd_corner      = r_corner;

    always_comb begin
        n_state  = r_state;
        n_active = r_active;
        n_region = r_region;
        n_corner = r_corner;
        n_done   = 1'b0;
        n_found  = r_found;
        n_bin    = r_bin;
        case (r_state)
            S_IDLE: begin
                if (classify) begin
                    n_active = active_cap;
                    n_region = '0;
                    n_corner = FIRST_CORNER;
                    if (active_cap == '0) begin
                        // No active region: answer not found at once.
                        n_done  = 1'b1;
                        n_found = 1'b0;
                        n_bin   = '0;
                    end else begin
                        n_state = S_RUN;
                    end
                end
            end
            S_RUN: begin
                if (r_corner == CLOSE_CORNER) begin
                    n_corner = FIRST_CORNER;
                    if (last_region) begin
                        n_state = S_DRAIN;
                    end else begin
                        n_region = r_region + RW'(1);
                    end
                end else begin
                    n_corner = r_corner + 3'd1;
                end
            end
            S_DRAIN: begin
                n_state = S_DRAIN;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (finish) begin
            n_state = S_IDLE;
            n_done  = 1'b1;
            n_found = finish_hit;
            n_bin   = finish_hit ? BIN_BITS'(i_status_region) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_done         <= 1'b0;
            r_region_count <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            if (i_cfg_we) begin
                r_region_count <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_active <= n_active;
        r_region <= n_region;
        r_corner <= n_corner;
        r_found  <= n_found;
        r_bin    <= n_bin;
    end

    assign o_done      = r_done;
    assign o_found     = r_found;
    assign o_bin_index = r_bin;

endmodule

// ===== src/qrpb_datapath.sv =====
// Datapath of the quadrilateral region point binner.
// Holds the vertex memory, the query point and the edge test pipeline that
// signs one cross product per cycle. Uses qrpb_pkg.
module qrpb_datapath
    import qrpb_pkg::*;
#(
    parameter int REGIONS    = 16,
    parameter int COORD_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_dp_cmd                       i_cmd,
    input  logic [((REGIONS > 1) ? $clog2(REGIONS) : 1)-1:0] i_rd_region,
    input  logic [2:0]                    i_rd_corner,
    input  logic [3:0]                    i_region_index,
    input  logic [1:0]                    i_vertex_index,
    input  logic [PORT_COORD_BITS-1:0]    i_coord_x,
    input  logic [PORT_COORD_BITS-1:0]    i_coord_y,
    output t_dp_status                    o_status,
    output logic [((REGIONS > 1) ? $clog2(REGIONS) : 1)-1:0] o_status_region
);

    localparam int RW    = (REGIONS > 1) ? $clog2(REGIONS) : 1;
    localparam int CW    = (COORD_BITS < PORT_COORD_BITS) ? COORD_BITS : PORT_COORD_BITS;
    localparam int DEPTH = REGIONS * CORNERS;
    localparam int PW    = 2 * CW + 2;

    logic [2*CW-1:0] r_mem [0:DEPTH-1];
    logic [RW+1:0]   wr_addr, rd_addr;

    logic [CW-1:0]   r_px, r_py;
    logic [2*CW-1:0] r_rd;
    logic [CW-1:0]   r_prev_x, r_prev_y;
    logic [CW-1:0]   rd_x, rd_y;

    logic            r_s1_valid, r_s1_edge, r_s1_last;
    logic [RW-1:0]   r_s1_region;
    logic            r_s2_valid, r_s2_last;
    logic [RW-1:0]   r_s2_region;
    logic signed [CW:0] r_ex, r_ey, r_dx, r_dy;
    logic            r_s3_valid, r_s3_last;
    logic [RW-1:0]   r_s3_region;
    logic signed [PW-1:0] r_p1, r_p2;
    logic            r_s4_valid, r_s4_last, r_s4_pos;
    logic [RW-1:0]   r_s4_region;
    logic signed [PW:0] cross_sum;
    logic            r_outside;
    logic            region_done;

    assign wr_addr = {RW'(i_region_index), i_vertex_index};
    assign rd_addr = {i_rd_region,
                      (i_rd_corner == CLOSE_CORNER) ? 2'd0 : i_rd_corner[1:0]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.write) begin
            r_mem[wr_addr] <= {CW'(i_coord_x), CW'(i_coord_y)};
        end
        r_rd <= r_mem[rd_addr];
    end

    assign rd_x = r_rd[2*CW-1:CW];
    assign rd_y = r_rd[CW-1:0];

    // Pipeline valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
            r_outside  <= 1'b0;
        end else begin
            r_s1_valid <= i_cmd.issue & ~i_cmd.flush;
            r_s2_valid <= r_s1_valid & r_s1_edge & ~i_cmd.flush;
            r_s3_valid <= r_s2_valid & ~i_cmd.flush;
            r_s4_valid <= r_s3_valid & ~i_cmd.flush;
            if (i_cmd.flush || region_done) begin
                r_outside <= 1'b0;
            end else if (r_s4_valid) begin
                r_outside <= r_outside | r_s4_pos;
            end
        end
    end

    // Payload stages. Each corner read closes the edge from the corner before.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_point) begin
            r_px <= CW'(i_coord_x);
            r_py <= CW'(i_coord_y);
        end
        r_s1_edge   <= (i_rd_corner != FIRST_CORNER);
        r_s1_last   <= (i_rd_corner == CLOSE_CORNER);
        r_s1_region <= i_rd_region;
        if (r_s1_valid) begin
            r_prev_x <= rd_x;
            r_prev_y <= rd_y;
        end
        r_ex        <= $signed({1'b0, rd_x}) - $signed({1'b0, r_prev_x});
        r_ey        <= $signed({1'b0, rd_y}) - $signed({1'b0, r_prev_y});
        r_dx        <= $signed({1'b0, r_px}) - $signed({1'b0, r_prev_x});
        r_dy        <= $signed({1'b0, r_py}) - $signed({1'b0, r_prev_y});
        r_s2_last   <= r_s1_last;
        r_s2_region <= r_s1_region;
        r_p1        <= r_ex * r_dy;
        r_p2        <= r_ey * r_dx;
        r_s3_last   <= r_s2_last;
        r_s3_region <= r_s2_region;
        r_s4_pos    <= ~cross_sum[PW] & (|cross_sum);
        r_s4_last   <= r_s3_last;
        r_s4_region <= r_s3_region;
    end

    assign cross_sum = (PW + 1)'(r_p1) - (PW + 1)'(r_p2);

    // A region matches when none of its edges saw a positive cross product.
    assign region_done          = r_s4_valid & r_s4_last;
    assign o_status.region_done = region_done;
    assign o_status.hit         = region_done & ~(r_outside | r_s4_pos);
    assign o_status_region      = r_s4_region;

endmodule

// ===== src/quad_region_point_binner_unit.sv =====
// Top level of the quadrilateral region point binner.
// Joins the controller and the datapath; uses qrpb_pkg, qrpb_ctrl and
// qrpb_datapath.
//
// Usage. One input word is taken at a rising edge where start is high and
// busy is low. An opcode of load writes one corner of one region into the
// vertex memory in that same edge; it gives no result and the block stays
// free, so loads can follow each other on every cycle. A load whose region
// index lies beyond the table is dropped. An opcode of classify captures the
// query point and raises busy while the active regions are tested in index
// order; the lowest region whose edges all give a cross product of zero
// or less is reported. The result word shows on o_found and o_bin_index,
// marked by o_done for exactly one cycle; the receiver has no way to hold it.
// Timing. Each region takes five reads of the vertex memory (its four corners
// and the first corner again to close the last edge), one read a cycle, and
// each edge then passes through the registered stages of the edge pipeline.
// A region count of zero answers in the next cycle. The single memory read
// port sets the pace of the reads. The user must write the region count
// through i_cfg_we and i_cfg_wdata only while the block is idle; the block
// itself does not enforce this. Reset clears the region count and the
// control state; vertex memory contents are undefined until loaded.
module quad_region_point_binner_unit
    import qrpb_pkg::*;
#(
    parameter int REGIONS    = 16,
    parameter int COORD_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_opcode,
    input  logic [3:0]                 i_region_index,
    input  logic [1:0]                 i_vertex_index,
    input  logic [PORT_COORD_BITS-1:0] i_coord_x,
    input  logic [PORT_COORD_BITS-1:0] i_coord_y,
    input  logic                       i_cfg_we,
    input  logic [COUNT_BITS-1:0]      i_cfg_wdata,
    output logic                       o_done,
    output logic                       o_found,
    output logic [BIN_BITS-1:0]        o_bin_index
);

    localparam int RW = (REGIONS > 1) ? $clog2(REGIONS) : 1;

    t_dp_cmd    cmd;
    t_dp_status status;
    logic [RW-1:0] rd_region;
    logic [RW-1:0] status_region;
    logic [2:0]    rd_corner;

    // The controller sequences regions and corners and owns the result word.
    qrpb_ctrl #(
        .REGIONS(REGIONS)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_opcode       (i_opcode),
        .i_region_index (i_region_index),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_cmd          (cmd),
        .o_rd_region    (rd_region),
        .o_rd_corner    (rd_corner),
        .i_status       (status),
        .i_status_region(status_region),
        .o_done         (o_done),
        .o_found        (o_found),
        .o_bin_index    (o_bin_index)
    );

    // The datapath holds the vertices and signs one edge cross product a cycle.
    qrpb_datapath #(
        .REGIONS   (REGIONS),
        .COORD_BITS(COORD_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_rd_region    (rd_region),
        .i_rd_corner    (rd_corner),
        .i_region_index (i_region_index),
        .i_vertex_index (i_vertex_index),
        .i_coord_x      (i_coord_x),
        .i_coord_y      (i_coord_y),
        .o_status       (status),
        .o_status_region(status_region)
    );

endmodule

// ===== src/qrpb_checker.sv =====
// Port level checks for the quadrilateral region point binner.
// Watches only the top level ports; bound to quad_region_point_binner_unit.
module qrpb_checker
    import qrpb_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input logic                i_opcode,
    input logic                o_done,
    input logic                o_found,
    input logic [BIN_BITS-1:0] o_bin_index
);

    // A miss always reports region zero.
    a_miss_bin_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_found) |-> (o_bin_index == '0))
        else $error("miss reported with a nonzero bin index");

    // A result word is only shown once the block is free again.
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result shown while busy");

    // The block only leaves the busy state by delivering a result.
    a_busy_ends_in_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_done)
        else $error("busy dropped without a result");

    // A classify either answers at once or keeps the block busy.
    a_classify_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_opcode == OP_CLASSIFY)) |=> (busy || o_done))
        else $error("classify word lost");

    // A vertex load gives no result and does not occupy the block.
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_opcode == OP_LOAD)) |=> (!busy && !o_done))
        else $error("vertex load produced a result or raised busy");

endmodule

bind quad_region_point_binner_unit qrpb_checker u_qrpb_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .start      (start),
    .busy       (busy),
    .i_opcode   (i_opcode),
    .o_done     (o_done),
    .o_found    (o_found),
    .o_bin_index(o_bin_index)
);

// ===== sim/testbench.sv =====
// Self-checking bench for quad_region_point_binner_unit: loads quadrilateral
// regions, classifies points against them and checks every result word.
// Depends on qrpb_pkg and the RTL under src; reads no files.
module testbench;
    import qrpb_pkg::*;

    localparam int REGIONS       = 16;
    localparam int TABLE_DEPTH   = REGIONS * CORNERS;
    // Slowest classify is a match in the last region, which takes as long as a
    // miss over all sixteen regions. The settle time covers both.
    localparam int SETTLE_CYCLES = 96;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int PHASE_WORDS   = 110;

    // One word as the sender sees it, plus how it is paced.
    typedef struct {
        logic                       op;
        logic [3:0]                 region;
        logic [1:0]                 corner;
        logic [PORT_COORD_BITS-1:0] x;
        logic [PORT_COORD_BITS-1:0] y;
        int unsigned                gap;    // idle cycles before it is offered
        bit                         drain;  // hold it until no result is owed
    } t_binner_word;

    typedef struct packed {
        logic                found;
        logic [BIN_BITS-1:0] bin_idx;
    } t_bin_result;

    logic                       i_clk          = 1'b0;
    logic                       i_rst_n        = 1'b0;
    logic                       start          = 1'b0;
    logic                       busy;
    logic                       i_opcode       = OP_LOAD;
    logic [3:0]                 i_region_index = '0;
    logic [1:0]                 i_vertex_index = '0;
    logic [PORT_COORD_BITS-1:0] i_coord_x      = '0;
    logic [PORT_COORD_BITS-1:0] i_coord_y      = '0;
    logic                       i_cfg_we       = 1'b0;
    logic [COUNT_BITS-1:0]      i_cfg_wdata    = '0;
    logic                       o_done;
    logic                       o_found;
    logic [BIN_BITS-1:0]        o_bin_index;

    quad_region_point_binner_unit #(
        .REGIONS    (REGIONS),
        .COORD_BITS (PORT_COORD_BITS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_opcode       (i_opcode),
        .i_region_index (i_region_index),
        .i_vertex_index (i_vertex_index),
        .i_coord_x      (i_coord_x),
        .i_coord_y      (i_coord_y),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_done         (o_done),
        .o_found        (o_found),
        .o_bin_index    (o_bin_index)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Words waiting to be offered, and bins owed by accepted classify words.
    t_binner_word word_queue[$];
    t_binner_word cur_word;
    t_bin_result  expected_bins[$];

    // The bench's own image of the block: corner memory and region count.
    logic [PORT_COORD_BITS-1:0] corner_x[TABLE_DEPTH];
    logic [PORT_COORD_BITS-1:0] corner_y[TABLE_DEPTH];
    logic [COUNT_BITS-1:0]      region_count_now = '0;

    // Stimulus bookkeeping: which corners have been loaded so far, and a rough
    // bounding box per region so that query points can be aimed inside.
    logic [CORNERS-1:0] corners_loaded[REGIONS];
    int unsigned        box_x0[REGIONS], box_x1[REGIONS];
    int unsigned        box_y0[REGIONS], box_y1[REGIONS];
    bit                 idle_mode;

    int error_count     = 0;
    int loads_taken     = 0;
    int classify_taken  = 0;
    int hit_count       = 0;
    int settings_used   = 0;
    int unsigned wait_cycles = 0;
    int cycle_count;

    // Classify a point against the active regions the way the block does:
    // region by region from index zero, an edge excludes the point only when
    // its cross product is strictly positive, first region that survives wins.
    function automatic t_bin_result locate_point(input logic [PORT_COORD_BITS-1:0] px,
                                                 input logic [PORT_COORD_BITS-1:0] py);
        t_bin_result res;
        int          live;
        int          a, b;
        bit          in_region;
        longint      ex, ey, dx, dy;
        res  = '0;
        live = (region_count_now > REGIONS) ? REGIONS : int'(region_count_now);
        for (int r = 0; r < live; r++) begin
            in_region = 1'b1;
            for (int k = 0; k < CORNERS; k++) begin
                a  = r * CORNERS + k;
                b  = r * CORNERS + (k + 1) % CORNERS;
                ex = longint'(corner_x[b]) - longint'(corner_x[a]);
                ey = longint'(corner_y[b]) - longint'(corner_y[a]);
                dx = longint'(px) - longint'(corner_x[a]);
                dy = longint'(py) - longint'(corner_y[a]);
                if (ex * dy - ey * dx > 0)
                    in_region = 1'b0;
            end
            if (in_region && !res.found) begin
                res.found   = 1'b1;
                res.bin_idx = BIN_BITS'(r);
            end
        end
        return res;
    endfunction

    task automatic push_word(input logic op, input logic [3:0] region,
                             input logic [1:0] corner,
                             input logic [PORT_COORD_BITS-1:0] x,
                             input logic [PORT_COORD_BITS-1:0] y, input bit drain);
        t_binner_word w;
        w.op     = op;
        w.region = region;
        w.corner = corner;
        w.x      = x;
        w.y      = y;
        w.gap    = idle_mode ? $urandom_range(0, 7) : 0;
        w.drain  = drain;
        if (op == OP_LOAD)
            corners_loaded[region][corner] = 1'b1;
        word_queue.push_back(w);
    endtask

    // Load one region as four corner words. Corners go bottom-left, top-left,
    // top-right, bottom-right, which is the winding that makes the interior
    // give non-positive cross products. A few shapes are deliberately bad:
    // wrong winding, a zero-length edge, or all four corners on one point.
    task automatic queue_region(input int r);
        int unsigned span, w, h, x0, y0, jw, jh, shape, rot, k;
        logic [PORT_COORD_BITS-1:0] vx[CORNERS], vy[CORNERS];
        logic [PORT_COORD_BITS-1:0] tx, ty;
        span = $urandom_range(0, 9);
        if (span == 0) begin
            w = 16'hFFFF;
            h = 16'hFFFF;
        end else begin
            w = $urandom_range(1, span < 6 ? 16'h0C00 : 16'h9000);
            h = $urandom_range(1, span < 6 ? 16'h0C00 : 16'h9000);
        end
        x0 = $urandom_range(0, 16'hFFFF - w);
        y0 = $urandom_range(0, 16'hFFFF - h);
        jw = (span == 0) ? 0 : w / 8;
        jh = (span == 0) ? 0 : h / 8;
        vx[0] = 16'(x0 + $urandom_range(0, jw));
        vy[0] = 16'(y0 + $urandom_range(0, jh));
        vx[1] = 16'(x0 + $urandom_range(0, jw));
        vy[1] = 16'(y0 + h - $urandom_range(0, jh));
        vx[2] = 16'(x0 + w - $urandom_range(0, jw));
        vy[2] = 16'(y0 + h - $urandom_range(0, jh));
        vx[3] = 16'(x0 + w - $urandom_range(0, jw));
        vy[3] = 16'(y0 + $urandom_range(0, jh));
        shape = $urandom_range(0, 31);
        if (shape == 0) begin
            tx = vx[1]; ty = vy[1];
            vx[1] = vx[3]; vy[1] = vy[3];
            vx[3] = tx;    vy[3] = ty;
        end else if (shape == 1) begin
            vx[2] = vx[1];
            vy[2] = vy[1];
        end else if (shape == 2) begin
            for (int i = 1; i < CORNERS; i++) begin
                vx[i] = vx[0];
                vy[i] = vy[0];
            end
        end
        box_x0[r] = x0;
        box_x1[r] = x0 + w;
        box_y0[r] = y0;
        box_y1[r] = y0 + h;
        rot = $urandom_range(0, CORNERS - 1);
        for (int i = 0; i < CORNERS; i++) begin
            k = (rot + i) % CORNERS;
            push_word(OP_LOAD, 4'(r), 2'(k), vx[k], vy[k], 1'b0);
        end
    endtask

    // Query point: mostly inside the box of an active region, some on a box
    // corner, some at the coordinate extremes, the rest anywhere.
    task automatic queue_point(input bit drain);
        int unsigned live, r, pick;
        logic [PORT_COORD_BITS-1:0] px, py;
        t_binner_word w;
        live = (region_count_now > REGIONS) ? REGIONS : region_count_now;
        pick = $urandom_range(0, 9);
        r    = (live > 0) ? $urandom_range(0, live - 1) : 0;
        if (live > 0 && pick < 7) begin
            px = 16'($urandom_range(box_x0[r], box_x1[r]));
            py = 16'($urandom_range(box_y0[r], box_y1[r]));
        end else if (live > 0 && pick == 7) begin
            px = 16'($urandom_range(0, 1) ? box_x1[r] : box_x0[r]);
            py = 16'($urandom_range(0, 1) ? box_y1[r] : box_y0[r]);
        end else if (pick == 8) begin
            px = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            py = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        end else begin
            px = 16'($urandom_range(0, 16'hFFFF));
            py = 16'($urandom_range(0, 16'hFFFF));
        end
        // Region and corner fields mean nothing here; let them wander.
        push_word(OP_CLASSIFY, 4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)),
                  px, py, drain);
    endtask

    // Sampled at the falling edge, so the driver's work at the rising edge
    // has fully settled.
    task automatic wait_quiet();
        @(negedge i_clk);
        while (word_queue.size() != 0 || start || expected_bins.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // The count register may only change while the block is idle.
    task automatic set_region_count(input int value);
        int live;
        wait_quiet();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= COUNT_BITS'(value);
        @(posedge i_clk);
        i_cfg_we         <= 1'b0;
        region_count_now  = COUNT_BITS'(value);
        settings_used++;
        @(negedge i_clk);
        // Every region that a classify can reach must be fully loaded first.
        live = (value > REGIONS) ? REGIONS : value;
        for (int r = 0; r < live; r++)
            if (corners_loaded[r] != '1)
                queue_region(r);
    endtask

    // Driver. A word is taken at a rising edge where start is high and busy
    // is low; the bench's image of the block is updated at that same edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start       <= 1'b0;
            wait_cycles  = 0;
        end else begin
            if (start && !busy) begin
                if (cur_word.op == OP_LOAD) begin
                    corner_x[{cur_word.region, cur_word.corner}] = cur_word.x;
                    corner_y[{cur_word.region, cur_word.corner}] = cur_word.y;
                    loads_taken++;
                end else begin
                    expected_bins.push_back(locate_point(cur_word.x, cur_word.y));
                    classify_taken++;
                end
            end
            if (start && busy) begin
                // Word still on offer; keep everything as it is.
            end else if (word_queue.size() == 0) begin
                start <= 1'b0;
            end else if (wait_cycles < word_queue[0].gap) begin
                wait_cycles++;
                start <= 1'b0;
            end else if (word_queue[0].drain && expected_bins.size() != 0) begin
                start <= 1'b0;
            end else begin
                cur_word        = word_queue.pop_front();
                wait_cycles     = 0;
                start          <= 1'b1;
                i_opcode       <= cur_word.op;
                i_region_index <= cur_word.region;
                i_vertex_index <= cur_word.corner;
                i_coord_x      <= cur_word.x;
                i_coord_y      <= cur_word.y;
            end
        end
    end

    // Monitor. A result word lives for one cycle under o_done and cannot be
    // held off, so it is checked at the edge that ends that cycle.
    always @(posedge i_clk) begin
        t_bin_result want;
        if (i_rst_n && o_done !== 1'b0) begin
            if (expected_bins.size() == 0) begin
                error_count++;
                $display("%0t: result word found=%0b bin=%0d arrived with no classify owed",
                         $time, o_found, o_bin_index);
            end else begin
                want = expected_bins.pop_front();
                if (o_found !== want.found) begin
                    error_count++;
                    $display("%0t: found mismatch, expected %0b, actual %0b",
                             $time, want.found, o_found);
                end
                if (o_bin_index !== want.bin_idx) begin
                    error_count++;
                    $display("%0t: bin_index mismatch, expected %0d, actual %0d",
                             $time, want.bin_idx, o_bin_index);
                end
                if (want.found)
                    hit_count++;
            end
        end
    end

    // Watchdog for a hung block or a result that never shows.
    initial begin
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
            @(posedge i_clk);
        $display("%0t: run did not finish, %0d results still owed", $time,
                 expected_bins.size());
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        int phase_counts[8];
        int n, choice;
        phase_counts = '{16, 31, 0, 1, 17, 0, 0, 16};
        phase_counts[5] = $urandom_range(2, 15);
        phase_counts[6] = $urandom_range(0, 31);
        for (int r = 0; r < REGIONS; r++)
            corners_loaded[r] = '0;
        idle_mode = 1'b0;

        // Directed part, still under the reset count of zero: classify must
        // miss at both coordinate extremes.
        push_word(OP_CLASSIFY, 4'h0, 2'd0, 16'h0000, 16'h0000, 1'b0);
        push_word(OP_CLASSIFY, 4'hF, 2'd3, 16'hFFFF, 16'hFFFF, 1'b0);
        // Region 0 is a triangle: its last two corners coincide, leaving a
        // zero-length edge. The hypotenuse runs corner to corner diagonally.
        push_word(OP_LOAD, 4'h0, 2'd0, 16'h1000, 16'h1000, 1'b0);
        push_word(OP_LOAD, 4'h0, 2'd1, 16'h1000, 16'h3000, 1'b0);
        push_word(OP_LOAD, 4'h0, 2'd2, 16'h3000, 16'h3000, 1'b0);
        push_word(OP_LOAD, 4'h0, 2'd3, 16'h3000, 16'h3000, 1'b0);
        // Region 1 spans the whole coordinate range.
        push_word(OP_LOAD, 4'h1, 2'd0, 16'h0000, 16'h0000, 1'b0);
        push_word(OP_LOAD, 4'h1, 2'd1, 16'h0000, 16'hFFFF, 1'b0);
        push_word(OP_LOAD, 4'h1, 2'd2, 16'hFFFF, 16'hFFFF, 1'b0);
        push_word(OP_LOAD, 4'h1, 2'd3, 16'hFFFF, 16'h0000, 1'b0);
        // A lone corner of the top region; the rest is filled when needed.
        push_word(OP_LOAD, 4'hF, 2'd3, 16'hFFFF, 16'hFFFF, 1'b0);
        box_x0[0] = 16'h1000; box_x1[0] = 16'h3000;
        box_y0[0] = 16'h1000; box_y1[0] = 16'h3000;
        box_x0[1] = 16'h0000; box_x1[1] = 16'hFFFF;
        box_y0[1] = 16'h0000; box_y1[1] = 16'hFFFF;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // One region: inside, on the hypotenuse (a zero cross product counts
        // as inside), on a vertex, and beyond the hypotenuse.
        set_region_count(1);
        push_word(OP_CLASSIFY, 4'h0, 2'd0, 16'h1800, 16'h2000, 1'b0);
        push_word(OP_CLASSIFY, 4'h0, 2'd0, 16'h2000, 16'h2000, 1'b0);
        push_word(OP_CLASSIFY, 4'h0, 2'd0, 16'h1000, 16'h1000, 1'b0);
        push_word(OP_CLASSIFY, 4'h0, 2'd0, 16'h2800, 16'h1800, 1'b0);
        // Two regions: the point that missed now lands in region 1, and the
        // far extremes too; inside both, region 0 still wins.
        set_region_count(2);
        push_word(OP_CLASSIFY, 4'h0, 2'd0, 16'h2800, 16'h1800, 1'b0);
        push_word(OP_CLASSIFY, 4'h0, 2'd0, 16'hFFFF, 16'h0000, 1'b0);
        push_word(OP_CLASSIFY, 4'h0, 2'd0, 16'h0000, 16'hFFFF, 1'b0);
        push_word(OP_CLASSIFY, 4'h0, 2'd0, 16'h1800, 16'h2000, 1'b0);

        // Random part: each phase picks a region count (zero, one, the table
        // size and values past it among them) and mixes region reloads, single
        // corner rewrites and classify words. Pacing changes now and then.
        foreach (phase_counts[p]) begin
            set_region_count(phase_counts[p]);
            idle_mode = ($urandom_range(0, 3) != 0);
            n = 0;
            while (n < PHASE_WORDS) begin
                if ($urandom_range(0, 29) == 0)
                    idle_mode = !idle_mode;
                choice = $urandom_range(0, 19);
                if (choice < 3) begin
                    queue_region($urandom_range(0, REGIONS - 1));
                    n += CORNERS;
                end else if (choice == 3) begin
                    push_word(OP_LOAD, 4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)),
                              16'($urandom_range(0, 16'hFFFF)),
                              16'($urandom_range(0, 16'hFFFF)), 1'b0);
                    n++;
                end else begin
                    // Now and then the sender holds back until the block has
                    // answered everything it owes.
                    queue_point(choice == 4);
                    n++;
                end
            end
        end

        wait_quiet();
        $display("Run covered %0d vertex loads and %0d classify words (%0d found a region)",
                 loads_taken, classify_taken, hit_count);
        $display("across %0d region-count settings, including zero and values past the table.",
                 settings_used);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
